// ===== hdl/lzw_byte_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// LZW byte encoder assertion macros
// Shared property macros for the encoder's checker.
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_ENCODER_ASSERT_SVH
`define LZW_BYTE_ENCODER_ASSERT_SVH

// next-cycle implication, masked while reset is high
`define LBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw_byte_encoder check failed");

// next-cycle implication that also holds across reset
`define LBE_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lzw_byte_encoder reset check failed");

`endif

// ===== hdl/lbe_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder package
// Transaction types, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package lbe_pkg;

   localparam int BYTE_BITS     = 8;
   localparam int OUT_CODE_BITS = 12;
   localparam int EPOCH_BITS    = 8;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 end_of_message;
   } req_type;

   typedef struct packed {
      logic [OUT_CODE_BITS-1:0] code_word;
      logic                     final_code;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_LAST  = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;      // latch byte and hash, start prefix if none
      logic rd;          // read hash slot
      logic take_hit;    // prefix <= matched code
      logic probe_next;  // advance to next slot
      logic miss;        // emit prefix, insert pair unless full, restart prefix
      logic emit_last;   // emit final prefix, end message
      logic clear_step;  // sweep one table slot
   } cmd_type;

   typedef struct packed {
      logic prefix_valid;
      logic last;
      logic hit;
      logic occupied;
      logic out_free;
      logic epoch_wrap;
      logic clear_done;
   } sts_type;

endpackage

// ===== hdl/lbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder controller
// Sequences accept, table probe, result emission and table sweep.
// ----------------------------------------------------------------------------
module lbe_ctrl import lbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.prefix_valid) begin
                  state_in = ST_READ;
               end else if (sts.last) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = sts.last ? ST_LAST : ST_IDLE;
            end else if (sts.occupied) begin
               cmd.probe_next = 1'b1;
               state_in       = ST_READ;
            end else if (sts.out_free) begin
               cmd.miss = 1'b1;
               state_in = sts.last ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST: begin
            if (sts.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = sts.epoch_wrap ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // sts.last is the latched flag, but in IDLE it must see the incoming one;
   // the datapath muxes that for us.
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lbe_datapath.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder datapath
// Prefix state, hashed dictionary memory and result register.
// ----------------------------------------------------------------------------
module lbe_datapath import lbe_pkg::*; #(
   parameter int CODE_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int TBL_BITS  = CODE_BITS + 1;
   localparam int TBL_DEPTH = 1 << TBL_BITS;
   localparam int KEY_BITS  = CODE_BITS + BYTE_BITS;
   localparam int ENT_BITS  = EPOCH_BITS + KEY_BITS + CODE_BITS;
   localparam int WIDE_BITS = CODE_BITS + OUT_CODE_BITS;

   logic [ENT_BITS-1:0]   mem [TBL_DEPTH];
   logic [ENT_BITS-1:0]   rd_ff;

   logic [BYTE_BITS-1:0]  byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic [CODE_BITS-1:0]  prefix_ff, prefix_in;
   logic                  pvalid_ff, pvalid_in;
   logic [CODE_BITS:0]    next_ff, next_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [TBL_BITS-1:0]   addr_ff, addr_in;
   logic [TBL_BITS-1:0]   clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [TBL_BITS-1:0]   hash_idx;
   logic [KEY_BITS-1:0]   key;
   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [KEY_BITS-1:0]   rd_key;
   logic [CODE_BITS-1:0]  rd_code;
   logic [WIDE_BITS-1:0]  prefix_wide;
   logic                  full;
   logic                  out_free;
   logic                  mem_we;
   logic [TBL_BITS-1:0]   mem_wa;
   logic [ENT_BITS-1:0]   mem_wd;

   assign hash_idx = TBL_BITS'(prefix_ff)
                   ^ (TBL_BITS'(req.data_byte) << (TBL_BITS - BYTE_BITS));
   assign key      = {prefix_ff, byte_ff};
   assign rd_epoch = rd_ff[ENT_BITS-1 -: EPOCH_BITS];
   assign rd_key   = rd_ff[CODE_BITS +: KEY_BITS];
   assign rd_code  = rd_ff[CODE_BITS-1:0];
   assign full     = next_ff[CODE_BITS];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign prefix_wide = WIDE_BITS'(prefix_ff);

   assign sts.prefix_valid = pvalid_ff;
   assign sts.last         = cmd.accept ? req.end_of_message : last_ff;
   assign sts.occupied     = (rd_epoch == epoch_ff);
   assign sts.hit          = sts.occupied && (rd_key == key);
   assign sts.out_free     = out_free;
   assign sts.epoch_wrap   = (epoch_ff == {EPOCH_BITS{1'b1}});
   assign sts.clear_done   = (clr_ff == {TBL_BITS{1'b1}});

   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      pvalid_in    = pvalid_ff;
      next_in      = next_ff;
      epoch_in     = epoch_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         byte_in = req.data_byte;
         last_in = req.end_of_message;
         addr_in = hash_idx;
         if (!pvalid_ff) begin
            prefix_in = CODE_BITS'(req.data_byte);
            pvalid_in = 1'b1;
         end
      end
      if (cmd.take_hit) begin
         prefix_in = rd_code;
      end
      if (cmd.probe_next) begin
         addr_in = addr_ff + 1'b1;
      end
      if (cmd.miss) begin
         rsp_in       = '{code_word: prefix_wide[OUT_CODE_BITS-1:0], final_code: 1'b0};
         rsp_valid_in = 1'b1;
         prefix_in    = CODE_BITS'(byte_ff);
         if (!full) begin
            next_in = next_ff + 1'b1;
         end
      end
      if (cmd.emit_last) begin
         rsp_in       = '{code_word: prefix_wide[OUT_CODE_BITS-1:0], final_code: 1'b1};
         rsp_valid_in = 1'b1;
         pvalid_in    = 1'b0;
         next_in      = (CODE_BITS+1)'(256);
         epoch_in     = epoch_ff + 1'b1;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
         if (sts.clear_done) begin
            epoch_in = EPOCH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff    <= 1'b0;
         next_ff      <= (CODE_BITS+1)'(256);
         epoch_ff     <= EPOCH_BITS'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pvalid_ff    <= pvalid_in;
         next_ff      <= next_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      prefix_ff <= prefix_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   // dictionary table: one write port, one registered read port
   assign mem_we = cmd.clear_step || (cmd.miss && !full);
   assign mem_wa = cmd.clear_step ? clr_ff : addr_ff;
   assign mem_wd = cmd.clear_step ? '0 : {epoch_ff, key, next_ff[CODE_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd) begin
         rd_ff <= mem[addr_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/lzw_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder
// Streaming LZW compressor: bytes in, dictionary codes out.
// ----------------------------------------------------------------------------
// One byte per input transaction; end_of_message closes the message. A byte
// with no prefix before it is taken in IDLE, and goes to LAST if it ends the
// message. Any other byte passes READ and CHECK, once more for each extra
// probe of the hashed dictionary table (linear probing over 2^(CODE_BITS+1)
// slots, one registered read per probe), then LAST if it ends the message; a
// miss in CHECK and LAST both wait for the result register to drain. A
// message may yield one or two result transactions for its last byte. The
// table is invalidated at end of message by bumping an 8-bit epoch tag;
// after reset, and once every 255 messages when the tag wraps, a sweep over
// all 2^(CODE_BITS+1) slots (8192 at the default) clears the table while
// req_stall stays high. Codes wider than 12 bits are truncated to code_word.
// ----------------------------------------------------------------------------
module lzw_byte_encoder import lbe_pkg::*; #(
   parameter int CODE_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   cmd_type cmd;
   sts_type sts;

   // controller: state sequencing only
   lbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: prefix, table memory, result register
   lbe_datapath #(
      .CODE_BITS (CODE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

// ===== hdl/lbe_checker.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_byte_encoder_assert.svh"

module lbe_checker import lbe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // stalled result transaction holds
   `LBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

   // last byte always leaves work behind, so input stalls next cycle
   `LBE_ASSERT_NEXT(a_eom_busy, clock, reset, req_valid && !req_stall && req.end_of_message, req_stall)

   // table sweep follows reset
   `LBE_ASSERT_ALWAYS(a_rst_stall, clock, reset, req_stall)

   // no result right after reset
   `LBE_ASSERT_ALWAYS(a_rst_rsp, clock, reset, !rsp_valid)

endmodule

bind lzw_byte_encoder lbe_checker u_lbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ===== dv/lzw_byte_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// LZW byte encoder testbench
// Drives byte transactions, predicts emitted codes with a local LZW model and
// checks every result transaction in order, under random idling and stalls.
// ----------------------------------------------------------------------------

class lzw_code_board;
   typedef lbe_pkg::rsp_type rsp_pkt_t;

   // local copy of encoder state
   bit [11:0] prefix_code;
   bit        prefix_held;
   int        next_code;
   bit [19:0] dict [0:3839];   // {prefix, byte}
   rsp_pkt_t  pending [$];
   int        mismatches;

   function new();
      clear_dict();
      prefix_code = 0;
      mismatches  = 0;
   endfunction

   function void clear_dict();
      prefix_held = 0;
      next_code   = 256;
      prefix_code = 0;
   endfunction

   function void push_code(bit [11:0] c, bit f);
      rsp_pkt_t r;
      r.code_word  = c;
      r.final_code = f;
      pending.push_back(r);
   endfunction

   // note one accepted byte transaction
   function void note_byte(lbe_pkg::req_type t);
      bit [7:0] b;
      bit       hit;
      int       i;
      b   = t.data_byte;
      hit = 0;
      if (!prefix_held) begin
         prefix_code = 12'(b);
         prefix_held = 1;
      end else begin
         for (i = 0; i < next_code - 256; i++)
            if (!hit && dict[i] == {prefix_code, b}) begin
               hit = 1;
               prefix_code = 12'(256 + i);
            end
         if (!hit) begin
            push_code(prefix_code, 1'b0);
            if (next_code < 4096) begin
               dict[next_code - 256] = {prefix_code, b};
               next_code++;
            end
            prefix_code = 12'(b);
         end
      end
      if (t.end_of_message) begin
         push_code(prefix_code, 1'b1);
         clear_dict();
      end
   endfunction

   // check one accepted result transaction
   function void check_code(lbe_pkg::rsp_type got);
      rsp_pkt_t want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected code %0d final %0b", got.code_word, got.final_code);
         return;
      end
      want = pending.pop_front();
      if (want.code_word !== got.code_word || want.final_code !== got.final_code) begin
         mismatches++;
         if (mismatches <= 10)
            $display("code mismatch: exp %0d/%0b got %0d/%0b", want.code_word,
                     want.final_code, got.code_word, got.final_code);
      end
   endfunction
endclass

module lzw_byte_encoder_tb;
   import lbe_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   lzw_code_board board;

   int  send_idle_pct;     // sender idle percentage
   int  recv_idle_pct;     // receiver idle percentage
   bit  hold_rsp;          // long receiver hold-off request
   int  quiet_cycles;      // watchdog: cycles without any transaction
   bit  stim_done;

   localparam int WATCHDOG_LIMIT = 200000;  // covers the table sweep and stalls

   lzw_byte_encoder #(.CODE_BITS(12)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // send one byte transaction; random idle before offering
   task automatic send_byte(bit [7:0] b, bit eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req.data_byte <= b;
      req.end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one message of n bytes drawn from an alphabet of alpha values; small ones force dictionary hits
   task automatic send_message(int n, int alpha);
      int k;
      for (k = 0; k < n; k++)
         send_byte(8'($urandom_range(alpha - 1)), k == n - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // scoreboard taps on the accepting edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req);
         if (rsp_valid && !rsp_stall) board.check_code(rsp);
      end
   end

   // receiver stall: random idling or a long counted hold-off
   always @(posedge clock) begin
      int hold_cnt;
      if (hold_rsp && hold_cnt == 0) hold_cnt = 300;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
         if (hold_cnt == 0) hold_rsp = 0;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lzw_byte_encoder_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int phase;
      int k;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      rsp_stall = 1'b0;
      hold_rsp = 0;
      stim_done = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte messages at the byte extremes
      send_byte(8'h00, 1);
      send_byte(8'hFF, 1);
      // repeated byte: hits on dictionary strings
      for (k = 0; k < 8; k++) send_byte(8'hAA, k == 7);
      // alternating pattern and a two-byte message
      for (k = 0; k < 10; k++) send_byte(k[0] ? 8'h55 : 8'hAA, k == 9);
      send_byte(8'h01, 0);
      send_byte(8'h80, 1);
      wait_drained();

      // random phases with different idling mixes
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 24 : 0;
         if (phase == 1) hold_rsp = 1;   // receiver backs up while sender keeps offering
         k = 0;
         while (k < 220) begin
            int n;
            n = $urandom_range(9) == 0 ? 1 : $urandom_range(2, 40);
            send_message(n, $urandom_range(4) == 0 ? 256 : $urandom_range(2, 6));
            k += n;
         end
         wait_drained();   // sender pauses until all codes are back
      end

      // one longer message of random bytes
      for (k = 0; k < 80; k++) send_byte(8'($urandom), k == 79);
      wait_drained();

      stim_done = 1;
      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("lzw_byte_encoder_tb: done, clean");
      else
         $display("lzw_byte_encoder_tb: done, errors");
      $finish;
   end
endmodule
